// ===== src/adp_pkg.sv =====
// ---------------------------------------------------------------------------
// adp_pkg: shared types and constants for the angle-domain pruning block
// Opcodes, datapath commands, control/status structs and fixed widths of
// the normalized vector arithmetic.
// ---------------------------------------------------------------------------
package adp_pkg;

   // default geometry
   localparam int COORD_WIDTH   = 20;
   localparam int COS_FRAC_BITS = 16;

   // normalized magnitudes lie in [2^29, 2^30)
   localparam int NORM_LO_BIT = 29;
   localparam int NORM_HI_BIT = 30;
   localparam int NORM_WIDTH  = 30;
   // sum of squares and integer root
   localparam int SQ_WIDTH    = 62;
   localparam int ROOT_WIDTH  = 32;

   typedef enum logic [1:0] {
      OP_ANCHOR_I = 2'd0,
      OP_ANCHOR_J = 2'd1,
      OP_POINT_I  = 2'd2,
      OP_POINT_J  = 2'd3
   } opcode_type;

   // vector slots
   localparam logic [1:0] VSEL_IJ = 2'd0;  // I - J
   localparam logic [1:0] VSEL_PJ = 2'd1;  // P - J
   localparam logic [1:0] VSEL_PI = 2'd2;  // P - I

   // cosine select
   localparam logic CSEL_J = 1'b0;
   localparam logic CSEL_I = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ANCHOR_I,
      CMD_ANCHOR_J,
      CMD_VLOAD,
      CMD_NORM,
      CMD_SQUARE,
      CMD_SQSUM,
      CMD_SQRT,
      CMD_DIV,
      CMD_STORE,
      CMD_MUL,
      CMD_SUM,
      CMD_UPDATE,
      CMD_RESULT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       accept;
      logic [1:0] vsel;
      logic       csel;
   } dp_ctrl_type;

   typedef struct packed {
      logic norm_done;
      logic vec_zero;
      logic sqrt_last;
      logic div_last;
   } dp_stat_type;

endpackage

// ===== src/adp_datapath.sv =====
// ---------------------------------------------------------------------------
// adp_datapath: anchors, unit-vector engine, cosines and pruning decision
// Normalizes one difference vector a bit per cycle, takes its integer root
// one bit pair per cycle and divides both components one quotient bit per
// cycle; then forms cosines from stored unit vectors.
// ---------------------------------------------------------------------------
module adp_datapath #(
   parameter int COORD_WIDTH   = adp_pkg::COORD_WIDTH,
   parameter int COS_FRAC_BITS = adp_pkg::COS_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  adp_pkg::dp_ctrl_type           ctl,
   input  logic signed [COORD_WIDTH-1:0]  px,
   input  logic signed [COORD_WIDTH-1:0]  py,
   output adp_pkg::dp_stat_type           stat,
   output logic                           rsp_remove,
   output logic signed [COORD_WIDTH-1:0]  rsp_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_y
);

   localparam int W   = COORD_WIDTH;
   localparam int F   = COS_FRAC_BITS;
   localparam int AW  = (W + 1 > 31) ? W + 1 : 31;
   localparam int UW  = F + 2;
   localparam int PW  = 2 * F + 4;
   localparam int SW  = 2 * F + 5;
   localparam int QW  = F + 5;
   localparam int DCW = $clog2(F + 1);
   localparam int NW_C = adp_pkg::NORM_WIDTH;
   localparam logic signed [QW-1:0] ONE_Q  = QW'(1) <<< F;
   localparam logic signed [QW-1:0] MONE_Q = -(QW'(1) <<< F);

   // anchors and point
   logic signed [W-1:0] ai_x_ff, ai_y_ff, aj_x_ff, aj_y_ff;
   logic signed [W-1:0] pt_x_ff, pt_y_ff;

   // vector engine
   logic                  sx_ff, sy_ff;
   logic [AW-1:0]         ax_ff, ay_ff;
   logic [2*NW_C-1:0]     sqx_ff, sqy_ff;
   logic [adp_pkg::SQ_WIDTH-1:0]   nn_ff, res_ff, bit_ff;
   logic [adp_pkg::ROOT_WIDTH-1:0] rx_ff, ry_ff;
   logic [F:0]            qx_ff, qy_ff;
   logic [DCW-1:0]        dk_ff;

   // unit vectors and cosines
   logic signed [UW-1:0]  ux_ff [3];
   logic signed [UW-1:0]  uy_ff [3];
   logic [2:0]            uv_ff;
   logic signed [PW-1:0]  prodx_ff, prody_ff;
   logic signed [UW-1:0]  cosj_ff, cosi_ff, lgj_ff, smi_ff;
   logic                  cjv_ff, civ_ff;
   logic                  rem_ff;
   logic signed [W-1:0]   ox_ff, oy_ff;

   // difference vector select
   logic signed [W:0] dx, dy;
   logic [W:0]        magx, magy;
   always_comb begin
      case (ctl.vsel)
         adp_pkg::VSEL_IJ: begin
            dx = (W+1)'(ai_x_ff) - (W+1)'(aj_x_ff);
            dy = (W+1)'(ai_y_ff) - (W+1)'(aj_y_ff);
         end
         adp_pkg::VSEL_PJ: begin
            dx = (W+1)'(pt_x_ff) - (W+1)'(aj_x_ff);
            dy = (W+1)'(pt_y_ff) - (W+1)'(aj_y_ff);
         end
         default: begin
            dx = (W+1)'(pt_x_ff) - (W+1)'(ai_x_ff);
            dy = (W+1)'(pt_y_ff) - (W+1)'(ai_y_ff);
         end
      endcase
      magx = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
      magy = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
   end

   // normalization status
   logic [AW-1:0] m_or;
   logic          vec_zero, norm_lo, norm_hi;
   assign m_or     = ax_ff | ay_ff;
   assign vec_zero = (m_or == '0);
   assign norm_lo  = (m_or[AW-1:adp_pkg::NORM_LO_BIT] == '0);
   assign norm_hi  = |m_or[AW-1:adp_pkg::NORM_HI_BIT];

   logic [NW_C-1:0] ax_n, ay_n;
   assign ax_n = ax_ff[NW_C-1:0];
   assign ay_n = ay_ff[NW_C-1:0];

   // root step
   logic [adp_pkg::SQ_WIDTH-1:0] sq_t;
   logic                         sq_ge;
   assign sq_t  = res_ff + bit_ff;
   assign sq_ge = (nn_ff >= sq_t);

   // quotient step
   logic [adp_pkg::ROOT_WIDTH-1:0] root;
   logic                           gx, gy;
   assign root = res_ff[adp_pkg::ROOT_WIDTH-1:0];
   assign gx   = (rx_ff >= root);
   assign gy   = (ry_ff >= root);

   // dot product operands
   logic signed [UW-1:0] opax, opay, opbx, opby;
   always_comb begin
      if (ctl.csel == adp_pkg::CSEL_I) begin
         opax = ux_ff[adp_pkg::VSEL_PI];
         opay = uy_ff[adp_pkg::VSEL_PI];
         opbx = -ux_ff[adp_pkg::VSEL_IJ];
         opby = -uy_ff[adp_pkg::VSEL_IJ];
      end else begin
         opax = ux_ff[adp_pkg::VSEL_PJ];
         opay = uy_ff[adp_pkg::VSEL_PJ];
         opbx = ux_ff[adp_pkg::VSEL_IJ];
         opby = uy_ff[adp_pkg::VSEL_IJ];
      end
   end

   // sum, floor shift and clamp
   logic signed [SW-1:0] dot_s;
   logic signed [QW-1:0] dot_q;
   logic signed [UW-1:0] cos_in;
   always_comb begin
      dot_s = SW'(prodx_ff) + SW'(prody_ff);
      dot_q = QW'(dot_s >>> F);
      if (dot_q > ONE_Q)
         cos_in = UW'(ONE_Q);
      else if (dot_q < MONE_Q)
         cos_in = UW'(MONE_Q);
      else
         cos_in = UW'(dot_q);
   end

   logic ok_j, ok_i;
   assign ok_j = uv_ff[adp_pkg::VSEL_PJ] & uv_ff[adp_pkg::VSEL_IJ];
   assign ok_i = uv_ff[adp_pkg::VSEL_PI] & uv_ff[adp_pkg::VSEL_IJ];

   logic signed [UW-1:0] qsx, qsy;
   assign qsx = sx_ff ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
   assign qsy = sy_ff ? -$signed({1'b0, qy_ff}) : $signed({1'b0, qy_ff});

   // state with reset: anchors, valid flags, extremes
   always_ff @(posedge clock) begin
      if (reset) begin
         ai_x_ff <= '0; ai_y_ff <= '0;
         aj_x_ff <= '0; aj_y_ff <= '0;
         uv_ff   <= '0;
         cjv_ff  <= 1'b0; civ_ff <= 1'b0;
         lgj_ff  <= '0;   smi_ff <= '0;
      end else begin
         case (ctl.cmd)
            adp_pkg::CMD_ANCHOR_I: begin
               ai_x_ff <= pt_x_ff; ai_y_ff <= pt_y_ff;
               cjv_ff  <= 1'b0;    civ_ff  <= 1'b0;
               lgj_ff  <= '0;      smi_ff  <= '0;
            end
            adp_pkg::CMD_ANCHOR_J: begin
               aj_x_ff <= pt_x_ff; aj_y_ff <= pt_y_ff;
            end
            adp_pkg::CMD_STORE: uv_ff[ctl.vsel] <= !vec_zero;
            adp_pkg::CMD_UPDATE: begin
               if (ok_j) begin
                  if (!cjv_ff || cosj_ff > lgj_ff) lgj_ff <= cosj_ff;
                  cjv_ff <= 1'b1;
               end
               if (ok_i) begin
                  if (!civ_ff || cosi_ff < smi_ff) smi_ff <= cosi_ff;
                  civ_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         pt_x_ff <= px; pt_y_ff <= py;
      end
      case (ctl.cmd)
         adp_pkg::CMD_VLOAD: begin
            sx_ff <= dx[W]; sy_ff <= dy[W];
            ax_ff <= AW'(magx); ay_ff <= AW'(magy);
         end
         adp_pkg::CMD_NORM: begin
            if (norm_lo) begin
               ax_ff <= ax_ff << 1; ay_ff <= ay_ff << 1;
            end else if (norm_hi) begin
               ax_ff <= ax_ff >> 1; ay_ff <= ay_ff >> 1;
            end
         end
         adp_pkg::CMD_SQUARE: begin
            sqx_ff <= ax_n * ax_n;
            sqy_ff <= ay_n * ay_n;
         end
         adp_pkg::CMD_SQSUM: begin
            nn_ff  <= adp_pkg::SQ_WIDTH'(sqx_ff) + adp_pkg::SQ_WIDTH'(sqy_ff);
            res_ff <= '0;
            bit_ff <= adp_pkg::SQ_WIDTH'(1) << (adp_pkg::SQ_WIDTH - 2);
            rx_ff  <= adp_pkg::ROOT_WIDTH'(ax_n);
            ry_ff  <= adp_pkg::ROOT_WIDTH'(ay_n);
            qx_ff  <= '0; qy_ff <= '0;
            dk_ff  <= DCW'(F);
         end
         adp_pkg::CMD_SQRT: begin
            if (sq_ge) begin
               nn_ff  <= nn_ff - sq_t;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         adp_pkg::CMD_DIV: begin
            rx_ff <= (gx ? rx_ff - root : rx_ff) << 1;
            ry_ff <= (gy ? ry_ff - root : ry_ff) << 1;
            qx_ff <= {qx_ff[F-1:0], gx};
            qy_ff <= {qy_ff[F-1:0], gy};
            dk_ff <= dk_ff - DCW'(1);
         end
         adp_pkg::CMD_STORE: begin
            ux_ff[ctl.vsel] <= qsx;
            uy_ff[ctl.vsel] <= qsy;
         end
         adp_pkg::CMD_MUL: begin
            prodx_ff <= opax * opbx;
            prody_ff <= opay * opby;
         end
         adp_pkg::CMD_SUM: begin
            if (ctl.csel == adp_pkg::CSEL_I) cosi_ff <= cos_in;
            else cosj_ff <= cos_in;
         end
         adp_pkg::CMD_RESULT: begin
            rem_ff <= ok_j && ok_i && (!cjv_ff || cosj_ff > lgj_ff)
                      && (!civ_ff || cosi_ff < smi_ff);
            ox_ff  <= pt_x_ff;
            oy_ff  <= pt_y_ff;
         end
         default: ;
      endcase
   end

   assign stat.norm_done = vec_zero | (!norm_lo & !norm_hi);
   assign stat.vec_zero  = vec_zero;
   assign stat.sqrt_last = bit_ff[0];
   assign stat.div_last  = (dk_ff == '0);

   assign rsp_remove = rem_ff;
   assign rsp_x      = ox_ff;
   assign rsp_y      = oy_ff;

endmodule

// ===== src/adp_ctrl.sv =====
// ---------------------------------------------------------------------------
// adp_ctrl: sequencer for the angle-domain pruning datapath
// Steps each point through three unit vectors, two cosines and the final
// update or result beat.
// ---------------------------------------------------------------------------
module adp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  adp_pkg::opcode_type   opcode,
   input  logic                  rsp_ready,
   input  adp_pkg::dp_stat_type  stat,
   output adp_pkg::dp_ctrl_type  ctl,
   output logic                  req_ready,
   output logic                  rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_VLOAD, S_NORM, S_SQUARE, S_SQSUM, S_SQRT,
      S_DIV, S_STORE, S_MULJ, S_SUMJ, S_MULI, S_SUMI, S_FINISH, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   adp_pkg::opcode_type op_ff;
   logic [1:0]          vsel_ff;
   logic                ready_ff, valid_ff;
   logic                accept, out_fire;

   assign accept   = req_valid & ready_ff;
   assign out_fire = (state_ff == S_OUT) & (!valid_ff | rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (accept) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (op_ff == adp_pkg::OP_ANCHOR_I || op_ff == adp_pkg::OP_ANCHOR_J)
               state_in = S_IDLE;
            else
               state_in = S_VLOAD;
         end
         S_VLOAD:  state_in = S_NORM;
         S_NORM:   if (stat.norm_done) state_in = stat.vec_zero ? S_STORE : S_SQUARE;
         S_SQUARE: state_in = S_SQSUM;
         S_SQSUM:  state_in = S_SQRT;
         S_SQRT:   if (stat.sqrt_last) state_in = S_DIV;
         S_DIV:    if (stat.div_last) state_in = S_STORE;
         S_STORE:  state_in = (vsel_ff == adp_pkg::VSEL_PI) ? S_MULJ : S_VLOAD;
         S_MULJ:   state_in = S_SUMJ;
         S_SUMJ:   state_in = S_MULI;
         S_MULI:   state_in = S_SUMI;
         S_SUMI:   state_in = S_FINISH;
         S_FINISH: state_in = (op_ff == adp_pkg::OP_POINT_J) ? S_OUT : S_IDLE;
         S_OUT:    if (out_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      ctl.accept = accept;
      ctl.vsel   = vsel_ff;
      ctl.csel   = (state_ff == S_MULI || state_ff == S_SUMI)
                   ? adp_pkg::CSEL_I : adp_pkg::CSEL_J;
      case (state_ff)
         S_DISPATCH: begin
            if (op_ff == adp_pkg::OP_ANCHOR_I)      ctl.cmd = adp_pkg::CMD_ANCHOR_I;
            else if (op_ff == adp_pkg::OP_ANCHOR_J) ctl.cmd = adp_pkg::CMD_ANCHOR_J;
            else                                    ctl.cmd = adp_pkg::CMD_NONE;
         end
         S_VLOAD:  ctl.cmd = adp_pkg::CMD_VLOAD;
         S_NORM:   ctl.cmd = adp_pkg::CMD_NORM;
         S_SQUARE: ctl.cmd = adp_pkg::CMD_SQUARE;
         S_SQSUM:  ctl.cmd = adp_pkg::CMD_SQSUM;
         S_SQRT:   ctl.cmd = adp_pkg::CMD_SQRT;
         S_DIV:    ctl.cmd = adp_pkg::CMD_DIV;
         S_STORE:  ctl.cmd = adp_pkg::CMD_STORE;
         S_MULJ, S_MULI: ctl.cmd = adp_pkg::CMD_MUL;
         S_SUMJ, S_SUMI: ctl.cmd = adp_pkg::CMD_SUM;
         S_FINISH: ctl.cmd = (op_ff == adp_pkg::OP_POINT_I)
                             ? adp_pkg::CMD_UPDATE : adp_pkg::CMD_NONE;
         S_OUT:    ctl.cmd = out_fire ? adp_pkg::CMD_RESULT : adp_pkg::CMD_NONE;
         default:  ctl.cmd = adp_pkg::CMD_NONE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
         vsel_ff  <= adp_pkg::VSEL_IJ;
         op_ff    <= adp_pkg::OP_ANCHOR_I;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
         if (accept) op_ff <= opcode;
         if (state_ff == S_DISPATCH) vsel_ff <= adp_pkg::VSEL_IJ;
         else if (state_ff == S_STORE) vsel_ff <= vsel_ff + 2'd1;
         if (out_fire) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

// ===== src/angle_domain_pruning.sv =====
// ---------------------------------------------------------------------------
// angle_domain_pruning: prunes J-domain points against an I/J anchor pair
// Top level joining the sequencer and the arithmetic datapath.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one beat per command; tuser is the opcode (load anchor I
//   and clear, load anchor J, I-domain point, J-domain point), tdata the
//   point coordinates. rsp channel: one beat per J-domain point with the
//   remove flag and the echoed point.
//   Anchor loads pass through the idle state and dispatch. A point works
//   out three unit vectors one after another. A nonzero vector goes
//   through load, one-bit normalizing shifts plus a settle step, square,
//   sum, the bit-pair root iteration, the shift-subtract divider and a
//   store; a zero-length vector goes through load, the normalize check
//   and a store. The idle state that takes the beat, dispatch, the two
//   cosines and the finish step (the update for an I-domain point) come
//   on top, and a J-domain point adds an output step for its result. A
//   new command is taken only once the block is back in idle.
//   A finished result sits in an output register; the next item is taken
//   while it waits, and only a later result waits for it to be taken.
//   Synchronous reset clears anchors, accumulated cosines and both
//   channels' control state.
// ---------------------------------------------------------------------------
module angle_domain_pruning #(
   parameter int COORD_WIDTH   = adp_pkg::COORD_WIDTH,
   parameter int COS_FRAC_BITS = adp_pkg::COS_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // px, py
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // opcode
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // remove, out_x, out_y
   output logic [((2*COORD_WIDTH+8)/8)*8-1:0]       rsp_tdata
);

   localparam int W      = COORD_WIDTH;
   localparam int OUT_DW = ((2 * W + 8) / 8) * 8;

   adp_pkg::dp_ctrl_type ctl;
   adp_pkg::dp_stat_type stat;
   logic                 rsp_remove;
   logic signed [W-1:0]  rsp_x, rsp_y;

   adp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .opcode    (adp_pkg::opcode_type'(req_tuser)),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .ctl       (ctl),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   adp_datapath #(
      .COORD_WIDTH   (COORD_WIDTH),
      .COS_FRAC_BITS (COS_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .px         (req_tdata[W-1:0]),
      .py         (req_tdata[2*W-1:W]),
      .stat       (stat),
      .rsp_remove (rsp_remove),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y)
   );

   assign rsp_tdata = OUT_DW'({rsp_y, rsp_x, rsp_remove});

   // a command beat always starts a busy period
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready while a command is in work");

   // a result beat only appears out of the busy period that made it
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result beat raised while idle");

endmodule
